/* design/gra_pkg.sv */
// Shared types, codes and widths of the grid rectangle allocator.
`default_nettype none
package gra_pkg;

  localparam int GRID_X_DEF = 16;
  localparam int GRID_Y_DEF = 16;

  localparam int CMD_W      = 3;
  localparam int SIZE_W     = 5;
  localparam int CELL_W     = 6;
  localparam int POS_W      = 16;
  localparam int FOUND_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  // Signed coordinate width: cell index plus rectangle size never leaves it.
  localparam int CRD_W      = 8;
  // Pixel distance accumulator, signed.
  localparam int ACC_W      = 21;
  // Vertical run counter per column.
  localparam int RUN_W      = 6;

  localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST   = 3'd0,
    CMD_NEAREST = 3'd1,
    CMD_PLACE   = 3'd2,
    CMD_REMOVE  = 3'd3,
    CMD_CHECK   = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X_USED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y_USED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONT_W      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONT_H      = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NEAR,
    S_ROW_RD,
    S_ROW_WR,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SCAN,
    PH_NEAR,
    PH_RD,
    PH_WR
  } phase_t;

  typedef struct packed {
    logic   start;
    phase_t phase;
    logic   out_load;
  } ctl_t;

  typedef struct packed {
    logic scan_end;
    logic near_end;
    logic rows_end;
  } sts_t;

endpackage
`default_nettype wire

/* design/gra_ctrl.sv */
// Controller state machine of the grid rectangle allocator.
`default_nettype none
module gra_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [gra_pkg::CMD_W-1:0]   in_command,
  input  wire logic                        out_stall,
  input  wire gra_pkg::sts_t               sts,
  output gra_pkg::ctl_t                    ctl,
  output logic                             in_stall,
  output logic                             out_valid
);

  gra_pkg::state_t state_r, state_nxt;
  logic [gra_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign accept    = in_valid && (state_r == gra_pkg::S_IDLE);
  assign in_stall  = (state_r != gra_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    case (state_r)
      gra_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_command;
          case (in_command)
            gra_pkg::CMD_FIRST, gra_pkg::CMD_NEAREST: state_nxt = gra_pkg::S_SCAN;
            gra_pkg::CMD_PLACE, gra_pkg::CMD_REMOVE,
            gra_pkg::CMD_CHECK, gra_pkg::CMD_QUERY:   state_nxt = gra_pkg::S_ROW_RD;
            default:                                  state_nxt = gra_pkg::S_RESULT;
          endcase
        end
      end
      gra_pkg::S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = (cmd_r == gra_pkg::CMD_NEAREST) ? gra_pkg::S_NEAR : gra_pkg::S_RESULT;
        end
      end
      gra_pkg::S_NEAR: begin
        if (sts.near_end) state_nxt = gra_pkg::S_RESULT;
      end
      gra_pkg::S_ROW_RD: begin
        state_nxt = sts.rows_end ? gra_pkg::S_RESULT : gra_pkg::S_ROW_WR;
      end
      gra_pkg::S_ROW_WR: state_nxt = gra_pkg::S_ROW_RD;
      gra_pkg::S_RESULT: begin
        if (!out_valid_r || !out_stall) state_nxt = gra_pkg::S_IDLE;
      end
      default: state_nxt = gra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.start    = accept;
    ctl.phase    = gra_pkg::PH_IDLE;
    ctl.out_load = 1'b0;
    case (state_r)
      gra_pkg::S_SCAN:   ctl.phase = gra_pkg::PH_SCAN;
      gra_pkg::S_NEAR:   ctl.phase = gra_pkg::PH_NEAR;
      gra_pkg::S_ROW_RD: ctl.phase = gra_pkg::PH_RD;
      gra_pkg::S_ROW_WR: ctl.phase = gra_pkg::PH_WR;
      gra_pkg::S_RESULT: ctl.out_load = !out_valid_r || !out_stall;
      default:           ctl.phase = gra_pkg::PH_IDLE;
    endcase
    out_valid_nxt = ctl.out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gra_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cmd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != gra_pkg::S_IDLE))
    else $error("accepted item did not start work");

  a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gra_pkg::S_RESULT && !(out_valid_r && out_stall))
      |=> (state_r == gra_pkg::S_IDLE && out_valid_r))
    else $error("finished result was not loaded");

  a_write_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gra_pkg::S_ROW_WR) |=> (state_r == gra_pkg::S_ROW_RD))
    else $error("row update step did not return to row read");

endmodule
`default_nettype wire

/* design/gra_datapath.sv */
// Datapath of the grid rectangle allocator: registers, maps, scans and result.
`default_nettype none
module gra_datapath #(
  parameter int GRID_X = gra_pkg::GRID_X_DEF,
  parameter int GRID_Y = gra_pkg::GRID_Y_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire gra_pkg::ctl_t                       ctl,
  output gra_pkg::sts_t                            sts,
  input  wire logic [gra_pkg::CMD_W-1:0]           in_command,
  input  wire logic [gra_pkg::SIZE_W-1:0]          in_rect_w,
  input  wire logic [gra_pkg::SIZE_W-1:0]          in_rect_h,
  input  wire logic signed [gra_pkg::CELL_W-1:0]   in_cell_x,
  input  wire logic signed [gra_pkg::CELL_W-1:0]   in_cell_y,
  input  wire logic signed [gra_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic signed [gra_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic                                cfg_we,
  input  wire logic [gra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gra_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                     out_flag,
  output logic signed [gra_pkg::FOUND_W-1:0]       out_found_x,
  output logic signed [gra_pkg::FOUND_W-1:0]       out_found_y
);

  localparam int XAW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YAW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int CW  = gra_pkg::CRD_W;
  localparam int AW  = gra_pkg::ACC_W;
  localparam int RW  = gra_pkg::RUN_W;

  // Configuration registers.
  logic [4:0]  gx_used_r, gy_used_r;
  logic [9:0]  border_r;
  logic [11:0] pitch_x_r, pitch_y_r;
  logic [12:0] cont_w_r, cont_h_r;

  // Captured item.
  logic [gra_pkg::CMD_W-1:0]         cmd_r;
  logic [gra_pkg::SIZE_W-1:0]        w_r, h_r;
  logic signed [gra_pkg::CELL_W-1:0] cx_r, cy_r;
  logic signed [gra_pkg::POS_W-1:0]  px_r, py_r;

  logic [CW-1:0] ux, uy, w_ext, h_ext;
  logic signed [CW-1:0] cx8, cy8;

  always_comb begin
    ux = ({3'b0, gx_used_r} > CW'(GRID_X)) ? CW'(GRID_X) : {3'b0, gx_used_r};
    uy = ({3'b0, gy_used_r} > CW'(GRID_Y)) ? CW'(GRID_Y) : {3'b0, gy_used_r};
    w_ext = {3'b0, w_r};
    h_ext = {3'b0, h_r};
    cx8 = {{(CW-gra_pkg::CELL_W){cx_r[gra_pkg::CELL_W-1]}}, cx_r};
    cy8 = {{(CW-gra_pkg::CELL_W){cy_r[gra_pkg::CELL_W-1]}}, cy_r};
  end

  // Occupancy map, one row per entry, with row valid bits for reset.
  logic [GRID_X-1:0] occ_mem [GRID_Y];
  logic [GRID_Y-1:0] occ_vld_r;
  logic [GRID_X-1:0] occ_rd_r;
  logic              occ_rdv_r;
  logic              occ_re, occ_we;
  logic [YAW-1:0]    occ_ra, occ_wa;
  logic [GRID_X-1:0] occ_wd, row_data;

  // Fit map written by the row scan, read by the distance pass.
  logic [GRID_X-1:0] fit_mem [GRID_Y];
  logic [GRID_X-1:0] fit_rd_r;
  logic              fit_we;
  logic [YAW-1:0]    fit_wa;

  assign row_data = occ_rdv_r ? occ_rd_r : '0;

  // Row scan state.
  logic [CW-1:0] rr_r, pr_r;
  logic          pv_r;
  logic [RW-1:0] run_r [GRID_X];
  logic [RW-1:0] run_nxt [GRID_X];
  logic [GRID_X-1:0] wmask, shifted, widthok, rowok, fitrow;
  logic [XAW-1:0] fpos;
  logic [CW-1:0]  oy;
  logic           fit_wr_ok, scan_issue;

  // Distance pass state.
  logic [CW-1:0]        nx_r, ny_r;
  logic signed [AW-1:0] ax_r, ay_r, base_x, base_y;
  logic [AW-1:0]        dist_sum, best_r;
  logic                 q_vld_r, q_ok_r, near_issue, near_hit;
  logic [XAW-1:0]       q_x_r;
  logic [YAW-1:0]       q_y_r;
  logic [AW-1:0]        q_dist_r;

  // Row operations.
  localparam int SIZE_W_P = gra_pkg::SIZE_W + 1;
  logic [SIZE_W_P-1:0] k_r;
  logic signed [CW-1:0] row_s, cxw;
  logic                 row_in, busy_r, bounds_ok;
  logic [GRID_X-1:0]    pmask;

  // Search result.
  logic                      found_r;
  logic [gra_pkg::FOUND_W-1:0] fx_r, fy_r;

  always_comb begin
    for (int b = 0; b < GRID_X; b++) begin
      wmask[b] = CW'(b) < w_ext;
    end
    for (int x = 0; x < GRID_X; x++) begin
      shifted    = row_data >> x;
      widthok[x] = (CW'(x) < ux) && (CW'(x) + w_ext <= ux);
      rowok[x]   = widthok[x] && ((shifted & wmask) == '0);
      if (!rowok[x]) begin
        run_nxt[x] = '0;
      end else if (run_r[x] == '1) begin
        run_nxt[x] = run_r[x];
      end else begin
        run_nxt[x] = run_r[x] + 1'b1;
      end
      fitrow[x] = (h_r == '0) ? widthok[x] : (run_nxt[x] >= RW'(h_r));
    end
    fpos = '0;
    for (int x = GRID_X - 1; x >= 0; x--) begin
      if (fitrow[x]) fpos = XAW'(x);
    end
  end

  // A row completes origins whose rectangle ends on it.
  assign oy         = (h_r == '0) ? pr_r : (pr_r + CW'(1) - h_ext);
  assign fit_wr_ok  = pv_r && ((h_r == '0) || (pr_r + CW'(1) >= h_ext));
  assign scan_issue = (ctl.phase == gra_pkg::PH_SCAN) && (rr_r < uy);

  assign base_x = AW'(px_r) - AW'($signed({1'b0, border_r}));
  assign base_y = AW'(py_r) - AW'($signed({1'b0, border_r}));
  assign dist_sum = AW'(ax_r[AW-1] ? -ax_r : ax_r) + AW'(ay_r[AW-1] ? -ay_r : ay_r);
  assign near_issue = (ctl.phase == gra_pkg::PH_NEAR) && (nx_r < ux) && (ny_r < uy);
  assign near_hit   = (ctl.phase == gra_pkg::PH_NEAR) && q_vld_r && q_ok_r &&
                      fit_rd_r[q_x_r] && (q_dist_r < best_r);

  always_comb begin
    row_s  = cy8 + $signed({2'b0, k_r});
    row_in = (row_s >= 0) && (row_s < $signed(uy));
    cxw    = cx8 + $signed(w_ext);
    bounds_ok = (cxw <= $signed(ux)) && (cy8 + $signed(h_ext) <= $signed(uy));
    for (int b = 0; b < GRID_X; b++) begin
      pmask[b] = ($signed(CW'(b)) >= cx8) && ($signed(CW'(b)) < cxw) && (CW'(b) < ux);
    end
  end

  always_comb begin
    sts.scan_end = (rr_r >= uy) && !pv_r;
    sts.near_end = !((nx_r < ux) && (ny_r < uy)) && !q_vld_r;
    sts.rows_end = ({2'b0, k_r} >= h_ext);
  end

  always_comb begin
    occ_re = 1'b0;
    occ_ra = rr_r[YAW-1:0];
    occ_we = 1'b0;
    occ_wa = row_s[YAW-1:0];
    occ_wd = row_data | pmask;
    if (scan_issue) begin
      occ_re = 1'b1;
    end else if (ctl.phase == gra_pkg::PH_RD && !sts.rows_end && row_in) begin
      occ_re = 1'b1;
      occ_ra = row_s[YAW-1:0];
    end
    if (ctl.phase == gra_pkg::PH_WR && row_in) begin
      if (cmd_r == gra_pkg::CMD_PLACE) begin
        occ_we = 1'b1;
      end else if (cmd_r == gra_pkg::CMD_REMOVE) begin
        occ_we = 1'b1;
        occ_wd = row_data & ~pmask;
      end
    end
    fit_we = (ctl.phase == gra_pkg::PH_SCAN) && fit_wr_ok;
    fit_wa = oy[YAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    if (occ_re) begin
      occ_rd_r  <= occ_mem[occ_ra];
      occ_rdv_r <= occ_vld_r[occ_ra];
    end
    if (fit_we) fit_mem[fit_wa] <= fitrow;
    if (near_issue) fit_rd_r <= fit_mem[ny_r[YAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_vld_r <= '0;
      gx_used_r <= 5'd16;
      gy_used_r <= 5'd16;
      border_r  <= 10'd0;
      pitch_x_r <= 12'd64;
      pitch_y_r <= 12'd64;
      cont_w_r  <= 13'd1024;
      cont_h_r  <= 13'd1024;
    end else begin
      if (occ_we) occ_vld_r[occ_wa] <= 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          gra_pkg::CFG_GRID_X_USED: gx_used_r <= cfg_wdata[4:0];
          gra_pkg::CFG_GRID_Y_USED: gy_used_r <= cfg_wdata[4:0];
          gra_pkg::CFG_BORDER:      border_r  <= cfg_wdata[9:0];
          gra_pkg::CFG_PITCH_X:     pitch_x_r <= cfg_wdata[11:0];
          gra_pkg::CFG_PITCH_Y:     pitch_y_r <= cfg_wdata[11:0];
          gra_pkg::CFG_CONT_W:      cont_w_r  <= cfg_wdata;
          gra_pkg::CFG_CONT_H:      cont_h_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      q_vld_r <= 1'b0;
      found_r <= 1'b0;
    end else if (ctl.start) begin
      pv_r    <= 1'b0;
      q_vld_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (ctl.phase == gra_pkg::PH_SCAN) begin
        pv_r <= scan_issue;
        if (fit_wr_ok && (cmd_r == gra_pkg::CMD_FIRST) && (fitrow != '0) && !found_r) begin
          found_r <= 1'b1;
        end
      end
      if (ctl.phase == gra_pkg::PH_NEAR) begin
        q_vld_r <= near_issue;
        if (near_hit) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r <= in_command;
      w_r   <= (in_command == gra_pkg::CMD_QUERY) ? gra_pkg::SIZE_W'(1) : in_rect_w;
      h_r   <= (in_command == gra_pkg::CMD_QUERY) ? gra_pkg::SIZE_W'(1) : in_rect_h;
      cx_r  <= in_cell_x;
      cy_r  <= in_cell_y;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      rr_r  <= '0;
      nx_r  <= '0;
      ny_r  <= '0;
      k_r   <= '0;
      busy_r <= 1'b0;
      best_r <= AW'(cont_w_r) + AW'(cont_h_r);
      for (int x = 0; x < GRID_X; x++) run_r[x] <= '0;
    end else begin
      if (scan_issue) begin
        rr_r <= rr_r + CW'(1);
        pr_r <= rr_r;
      end
      if (ctl.phase == gra_pkg::PH_SCAN && pv_r) begin
        for (int x = 0; x < GRID_X; x++) run_r[x] <= run_nxt[x];
        if (fit_wr_ok && (cmd_r == gra_pkg::CMD_FIRST) && (fitrow != '0) && !found_r) begin
          fx_r <= gra_pkg::FOUND_W'(fpos);
          fy_r <= oy[gra_pkg::FOUND_W-1:0];
        end
      end
      // The first origin takes its distance straight from the base offsets; later
      // origins step the running offsets by one pitch.
      if (near_issue) begin
        q_x_r    <= nx_r[XAW-1:0];
        q_y_r    <= ny_r[YAW-1:0];
        q_ok_r   <= (ny_r + h_ext <= uy);
        q_dist_r <= (nx_r == '0 && ny_r == '0) ?
                    (AW'(base_x[AW-1] ? -base_x : base_x) +
                     AW'(base_y[AW-1] ? -base_y : base_y)) : dist_sum;
        if (ny_r + CW'(1) >= uy) begin
          ny_r <= '0;
          nx_r <= nx_r + CW'(1);
          ax_r <= ((nx_r == '0) ? base_x : ax_r) - AW'($signed({1'b0, pitch_x_r}));
          ay_r <= base_y;
        end else begin
          ny_r <= ny_r + CW'(1);
          if (nx_r == '0 && ny_r == '0) ax_r <= base_x;
          ay_r <= ((nx_r == '0 && ny_r == '0) ? base_y : ay_r) -
                  AW'($signed({1'b0, pitch_y_r}));
        end
      end
      if (near_hit) begin
        best_r <= q_dist_r;
        fx_r   <= gra_pkg::FOUND_W'(q_x_r);
        fy_r   <= gra_pkg::FOUND_W'(q_y_r);
      end
      if (ctl.phase == gra_pkg::PH_WR) begin
        k_r <= k_r + 1'b1;
        if (row_in && ((row_data & pmask) != '0)) busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (cmd_r)
        gra_pkg::CMD_FIRST, gra_pkg::CMD_NEAREST: begin
          out_flag    <= found_r;
          out_found_x <= found_r ? fx_r : gra_pkg::FOUND_NONE;
          out_found_y <= found_r ? fy_r : gra_pkg::FOUND_NONE;
        end
        gra_pkg::CMD_CHECK: begin
          out_flag    <= bounds_ok && !busy_r;
          out_found_x <= '0;
          out_found_y <= '0;
        end
        gra_pkg::CMD_QUERY: begin
          out_flag    <= busy_r;
          out_found_x <= '0;
          out_found_y <= '0;
        end
        default: begin
          out_flag    <= 1'b0;
          out_found_x <= '0;
          out_found_y <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/grid_rectangle_allocator.sv */
// Top level of the grid rectangle allocator: controller, datapath and ports.
// Per item: first fit scans each used row of the map, then loads the result;
// nearest fit then also walks every origin of the used grid before loading it.
// Place, remove and check take a read step and an update step per rectangle row, a query one row.
// One item is in work at a time; the next is taken in the cycle after a result enters the
// output register, and a result can only enter once the previous one has been taken.
// Synchronous reset frees every cell through per-row valid bits and loads the registers.
`default_nettype none
module grid_rectangle_allocator #(
  parameter int GRID_X = gra_pkg::GRID_X_DEF,
  parameter int GRID_Y = gra_pkg::GRID_Y_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [gra_pkg::CMD_W-1:0]           in_command,
  input  wire logic [gra_pkg::SIZE_W-1:0]          in_rect_w,
  input  wire logic [gra_pkg::SIZE_W-1:0]          in_rect_h,
  input  wire logic signed [gra_pkg::CELL_W-1:0]   in_cell_x,
  input  wire logic signed [gra_pkg::CELL_W-1:0]   in_cell_y,
  input  wire logic signed [gra_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic signed [gra_pkg::POS_W-1:0]    in_pos_y,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_flag,
  output logic signed [gra_pkg::FOUND_W-1:0]       out_found_x,
  output logic signed [gra_pkg::FOUND_W-1:0]       out_found_y,
  input  wire logic                                cfg_we,
  input  wire logic [gra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gra_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // The controller sequences each item through the datapath; the two talk only
  // through the command and status structs below.
  gra_pkg::ctl_t ctl;
  gra_pkg::sts_t sts;

  gra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_stall  (out_stall),
    .sts        (sts),
    .ctl        (ctl),
    .in_stall   (in_stall),
    .out_valid  (out_valid)
  );

  // The datapath scans one map row per cycle, keeping a run of fitting rows per
  // column, so every origin completed on that row is known at once. Nearest fit
  // then walks the stored fit map one origin per cycle, x outer and y inner.
  gra_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_command  (in_command),
    .in_rect_w   (in_rect_w),
    .in_rect_h   (in_rect_h),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_flag    (out_flag),
    .out_found_x (out_found_x),
    .out_found_y (out_found_y)
  );

endmodule
`default_nettype wire
